@@ rtl/bldc6_pkg.sv @@
// Shared types, window bounds and drive tables for the six-step commutator.
package bldc6_pkg;

    // Commutation step and sensed sector, 0 to 5.
    typedef logic [2:0] t_step;

    // Signed difference between position and phase offset.
    typedef logic signed [15:0] t_diff;

    // Half-bridge identifiers.
    typedef enum logic [1:0] {
        PH_U,
        PH_V,
        PH_W
    } t_phase;

    // Configuration register indexes.
    localparam logic [7:0] REG_PHASE_OFFSET = 8'd0;
    localparam logic [7:0] REG_DRIVE_DUTY   = 8'd1;

    localparam int POS_BITS  = 14;
    localparam int OFF_BITS  = 13;
    localparam int DUTY_OUT  = 10;

    // Sector codes.
    localparam t_step SECT_0 = 3'd0;
    localparam t_step SECT_1 = 3'd1;
    localparam t_step SECT_2 = 3'd2;
    localparam t_step SECT_3 = 3'd3;
    localparam t_step SECT_4 = 3'd4;
    localparam t_step SECT_5 = 3'd5;

    // Angle window bounds in 1/256 degree (floor of degrees times 256).
    localparam logic [POS_BITS-1:0] W5_LOW_MAX  = 14'd2296;
    localparam logic [POS_BITS-1:0] W5_HIGH_MIN = 14'd12928;
    localparam logic [POS_BITS-1:0] W0_LO       = 14'd2137;
    localparam logic [POS_BITS-1:0] W0_HI       = 14'd4477;
    localparam logic [POS_BITS-1:0] W1_LO       = 14'd4318;
    localparam logic [POS_BITS-1:0] W1_HI       = 14'd6684;
    localparam logic [POS_BITS-1:0] W2_LO       = 14'd6525;
    localparam logic [POS_BITS-1:0] W2_HI       = 14'd8911;
    localparam logic [POS_BITS-1:0] W3_LO       = 14'd8663;
    localparam logic [POS_BITS-1:0] W3_HI       = 14'd11059;
    localparam logic [POS_BITS-1:0] W4_LO       = 14'd10872;
    localparam logic [POS_BITS-1:0] W4_END      = 14'd13568;
    localparam logic [POS_BITS-1:0] W4_WRAP_MAX = 14'd222;

    // Upper hysteresis bound: smallest difference at or past step + 1.1 phases.
    function automatic t_diff hyst_hi(input t_step step);
        t_diff r;
        case (step)
            3'd0:    r = 16'sd2414;
            3'd1:    r = 16'sd4609;
            3'd2:    r = 16'sd6803;
            3'd3:    r = 16'sd8997;
            3'd4:    r = 16'sd11192;
            3'd5:    r = 16'sd13386;
            default: r = 16'sd2414;
        endcase
        return r;
    endfunction

    // Lower hysteresis bound: differences below it lie before step - 0.1 phases.
    function automatic t_diff hyst_lo(input t_step step);
        t_diff r;
        case (step)
            3'd0:    r = -16'sd219;
            3'd1:    r = 16'sd1975;
            3'd2:    r = 16'sd4170;
            3'd3:    r = 16'sd6364;
            3'd4:    r = 16'sd8558;
            3'd5:    r = 16'sd10753;
            default: r = -16'sd219;
        endcase
        return r;
    endfunction

    // Phase that carries PWM in each step.
    function automatic t_phase pwm_phase(input t_step step);
        t_phase r;
        case (step)
            3'd0:    r = PH_W;
            3'd1:    r = PH_V;
            3'd2:    r = PH_V;
            3'd3:    r = PH_U;
            3'd4:    r = PH_U;
            3'd5:    r = PH_W;
            default: r = PH_W;
        endcase
        return r;
    endfunction

    // Phase left floating in each step.
    function automatic t_phase float_phase(input t_step step);
        t_phase r;
        case (step)
            3'd0:    r = PH_V;
            3'd1:    r = PH_W;
            3'd2:    r = PH_U;
            3'd3:    r = PH_V;
            3'd4:    r = PH_W;
            3'd5:    r = PH_U;
            default: r = PH_V;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/bldc6_sector_dec.sv @@
// Angle window decoder from rotor position to sensed sector.
module bldc6_sector_dec
    import bldc6_pkg::*;
(
    input  logic [POS_BITS-1:0] i_pos,
    output t_step               o_sector
);

    logic w5, w0, w1, w2, w3, w4;

    // Window tests; earlier windows take priority among the first five.
    assign w5 = (i_pos <= W5_LOW_MAX) || (i_pos > W5_HIGH_MIN);
    assign w0 = (i_pos > W0_LO) && (i_pos <= W0_HI);
    assign w1 = (i_pos > W1_LO) && (i_pos <= W1_HI);
    assign w2 = (i_pos > W2_LO) && (i_pos <= W2_HI);
    assign w3 = (i_pos > W3_LO) && (i_pos <= W3_HI);
    // The sector 4 window overrides all others, including its wrap near zero.
    assign w4 = ((i_pos > W4_LO) && (i_pos < W4_END)) || (i_pos <= W4_WRAP_MAX);

    always_comb begin
        if (w4) begin
            o_sector = SECT_4;
        end else if (w5) begin
            o_sector = SECT_5;
        end else if (w0) begin
            o_sector = SECT_0;
        end else if (w1) begin
            o_sector = SECT_1;
        end else if (w2) begin
            o_sector = SECT_2;
        end else if (w3) begin
            o_sector = SECT_3;
        end else begin
            o_sector = SECT_0;
        end
    end

endmodule

@@ rtl/bldc_six_step_commutator.sv @@
// Six-step commutator: one sample in, one step and drive result out per cycle unless stalled.
// The block accepts one rotor position sample in every cycle unless the output stalls and
// returns one result per sample in the cycle after the transfer; the sector decode, hysteresis
// compare, step update and phase drive selection all sit in front of the single output
// register. The output register holds a result while the master side stalls and a new sample
// is taken in the same cycle the held result is transferred. The first sample after reset loads
// the step from the sensed sector; later samples advance or reload it when the position leaves
// the hysteresis window around the current phase centre. The user must write registers through
// the configuration channel only while no result is outstanding; the block does not enforce it.
module bldc_six_step_commutator
    import bldc6_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    // Position samples.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [13:0] rotor_position, [15:14] zero
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [2:0] commutation_step, [5:3] sensed_sector,
                                        // [15:6] u_duty, [25:16] v_duty, [35:26] w_duty,
                                        // [36] u_enable, [37] v_enable, [38] w_enable, [39] zero
);

    localparam int DW = (DUTY_BITS < DUTY_OUT) ? DUTY_BITS : DUTY_OUT;

    logic                       r_started;
    t_step                      r_step;
    t_step                      n_step;
    logic signed [OFF_BITS-1:0] r_offset;
    logic [DW-1:0]              r_duty;
    logic                       r_out_valid;
    logic [39:0]                r_out_data;
    logic [39:0]                n_out_data;

    logic                       in_xfer;
    logic [POS_BITS-1:0]        pos;
    t_step                      sector;
    t_diff                      diff;
    logic                       outside;
    t_phase                     ph_pwm;
    t_phase                     ph_float;
    logic [DUTY_OUT-1:0]        duty;
    logic [DUTY_OUT-1:0]        d_u, d_v, d_w;
    logic                       e_u, e_v, e_w;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign pos = s_axis_tdata[POS_BITS-1:0];

    bldc6_sector_dec u_dec (
        .i_pos    (pos),
        .o_sector (sector)
    );

    // Position relative to the trimmed phase origin, tested against the window of this step.
    assign diff    = $signed({2'b00, pos}) - t_diff'(r_offset);
    assign outside = (diff >= hyst_hi(r_step)) || (diff < hyst_lo(r_step));

    // Step update: load on the first sample, then advance or reload outside the window.
    always_comb begin
        n_step = r_step;
        if (!r_started) begin
            n_step = sector;
        end else if (outside) begin
            if (sector == r_step) begin
                n_step = (r_step == SECT_5) ? SECT_0 : t_step'(r_step + 3'd1);
            end else begin
                n_step = sector;
            end
        end
    end

    // Phase drive from the new step: one PWM phase, one grounded, one floating.
    assign ph_pwm   = pwm_phase(n_step);
    assign ph_float = float_phase(n_step);
    assign duty     = DUTY_OUT'(r_duty);

    always_comb begin
        d_u = (ph_pwm == PH_U) ? duty : '0;
        d_v = (ph_pwm == PH_V) ? duty : '0;
        d_w = (ph_pwm == PH_W) ? duty : '0;
        e_u = (ph_float != PH_U);
        e_v = (ph_float != PH_V);
        e_w = (ph_float != PH_W);
        n_out_data = {1'b0, e_w, e_v, e_u, d_w, d_v, d_u, sector, n_step};
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_duty   <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_addr == REG_PHASE_OFFSET) begin
                r_offset <= i_cfg_data[OFF_BITS-1:0];
            end else if (i_cfg_addr == REG_DRIVE_DUTY) begin
                r_duty <= i_cfg_data[DW-1:0];
            end
        end
    end

    // Commutation state, updated on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_step    <= SECT_0;
        end else if (in_xfer) begin
            r_started <= 1'b1;
            r_step    <= n_step;
        end
    end

    // Output register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    // Every input transfer produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> m_axis_tvalid)
        else $error("no result after an input transfer");

    // The step shown matches the held commutation state.
    a_step_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == r_step))
        else $error("result step differs from the held step");

    // Exactly one phase floats in every result.
    a_one_floating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(m_axis_tdata[38:36]) == 2))
        else $error("phase enables do not leave exactly one phase floating");

    // Once started, the step never leaves the range of six steps.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (r_step <= SECT_5))
        else $error("commutation step out of range");

endmodule
